// ===== hdl/jfhs_pkg.sv =====
`timescale 1ns / 1ps

package jfhs_pkg;

  // Marker bytes and codes used by the scanner.
  localparam logic [7:0] MK_FILL = 8'hff;
  localparam logic [7:0] MK_SOI  = 8'hd8;
  localparam logic [7:0] MK_EOI  = 8'hd9;
  localparam logic [7:0] MK_SOF0 = 8'hc0;
  localparam logic [7:0] MK_SOS  = 8'hda;
  localparam logic [7:0] MK_DHT  = 8'hc4;
  localparam logic [7:0] MK_JPG  = 8'hc8;
  localparam logic [7:0] MK_DAC  = 8'hcc;
  localparam logic [7:0] MK_TEM  = 8'h01;
  localparam logic [7:0] MK_RST0 = 8'hd0;
  localparam logic [7:0] MK_RST7 = 8'hd7;
  localparam logic [7:0] MK_NUL  = 8'h00;

  localparam logic [7:0] BASELINE_PRECISION = 8'd8;

  localparam logic [15:0] MAX_DIM_RESET = 16'd4096;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;
  localparam logic [1:0] ST_UNSUPP  = 2'd3;

  typedef enum logic [2:0] {
    PH_SOI0,
    PH_SOI1,
    PH_MARK,
    PH_FILL,
    PH_LEN0,
    PH_LEN1,
    PH_BODY
  } phase_t;

  // One result produced by the parser for the byte being taken.
  typedef struct packed {
    logic        valid;
    logic [1:0]  status;
    logic [15:0] width;
    logic [15:0] height;
    logic [1:0]  comps;
  } result_t;

endpackage

// ===== hdl/jfhs_parse.sv =====
`timescale 1ns / 1ps

module jfhs_parse import jfhs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  data_byte,
  input  logic        is_last,
  input  logic [15:0] max_dimension,
  output result_t     res
);

  phase_t      phase, phase_next;
  logic [2:0]  bytes_seen, bytes_seen_next;
  logic [7:0]  marker_code, marker_code_next;
  logic [15:0] segment_size, segment_size_next;
  logic [15:0] segment_progress, segment_progress_next;
  logic [7:0]  sample_precision, sample_precision_next;
  logic [15:0] frame_height, frame_height_next;
  logic [15:0] frame_width, frame_width_next;
  logic [7:0]  frame_components, frame_components_next;
  logic        verdict_given;

  logic        hit;
  logic [1:0]  hit_status;
  logic        judge_now;
  logic        is_frame;
  logic [9:0]  need_size;

  always_comb begin
    bytes_seen_next = (bytes_seen < 3'd4) ? bytes_seen + 3'd1 : bytes_seen;
    phase_next            = phase;
    marker_code_next      = marker_code;
    segment_size_next     = segment_size;
    segment_progress_next = segment_progress;
    sample_precision_next = sample_precision;
    frame_height_next     = frame_height;
    frame_width_next      = frame_width;
    frame_components_next = frame_components;
    hit        = 1'b0;
    hit_status = ST_INVALID;
    judge_now  = 1'b0;

    case (phase)
      PH_SOI0: begin
        if (data_byte != MK_FILL) hit = 1'b1;
        else phase_next = PH_SOI1;
      end
      PH_SOI1: begin
        if (data_byte != MK_SOI) hit = 1'b1;
        else phase_next = PH_MARK;
      end
      PH_MARK: begin
        if (data_byte != MK_FILL) hit = 1'b1;
        else phase_next = PH_FILL;
      end
      PH_FILL: begin
        if (data_byte != MK_FILL) begin
          marker_code_next = data_byte;
          if (data_byte == MK_NUL || data_byte == MK_EOI) begin
            hit = 1'b1;
          end else if (data_byte inside {MK_TEM, MK_SOI, [MK_RST0:MK_RST7]}) begin
            phase_next = PH_MARK;
          end else begin
            phase_next = PH_LEN0;
          end
        end
      end
      PH_LEN0: begin
        segment_size_next = {data_byte, 8'h00};
        phase_next = PH_LEN1;
      end
      PH_LEN1: begin
        segment_size_next = {segment_size[15:8], data_byte};
        if (segment_size_next < 16'd2) begin
          hit = 1'b1;
        end else begin
          segment_progress_next = 16'd2;
          if (segment_size_next == 16'd2) judge_now = 1'b1;
          else phase_next = PH_BODY;
        end
      end
      PH_BODY: begin
        case (segment_progress)
          16'd2:   sample_precision_next = data_byte;
          16'd3:   frame_height_next = {data_byte, 8'h00};
          16'd4:   frame_height_next = {frame_height[15:8], data_byte};
          16'd5:   frame_width_next = {data_byte, 8'h00};
          16'd6:   frame_width_next = {frame_width[15:8], data_byte};
          16'd7:   frame_components_next = data_byte;
          default: ;
        endcase
        segment_progress_next = segment_progress + 16'd1;
        if (segment_progress_next == segment_size) judge_now = 1'b1;
      end
      default: ;
    endcase

    // Judge a complete segment on the field values that include this byte.
    is_frame = (marker_code_next[7:4] == 4'hc) && (marker_code_next != MK_DHT) &&
               (marker_code_next != MK_JPG) && (marker_code_next != MK_DAC);
    need_size = 10'd8 + {2'b00, frame_components_next} +
                {1'b0, frame_components_next, 1'b0};
    if (judge_now) begin
      if (is_frame) begin
        hit = 1'b1;
        if (marker_code_next != MK_SOF0) begin
          hit_status = ST_UNSUPP;
        end else if (segment_size_next < 16'd8 ||
                     sample_precision_next != BASELINE_PRECISION ||
                     frame_width_next == 16'd0 || frame_height_next == 16'd0 ||
                     frame_width_next > max_dimension ||
                     frame_height_next > max_dimension ||
                     (frame_components_next != 8'd1 && frame_components_next != 8'd3) ||
                     segment_size_next != {6'b0, need_size}) begin
          hit_status = ST_INVALID;
        end else begin
          hit_status = ST_OK;
        end
      end else if (marker_code_next == MK_SOS) begin
        hit = 1'b1;
      end else begin
        phase_next = PH_MARK;
      end
    end

    res.valid  = take && !verdict_given && (hit || is_last);
    res.status = hit ? hit_status : ((bytes_seen_next < 3'd4) ? ST_INVALID : ST_TRUNC);
    if (hit && hit_status == ST_OK) begin
      res.width  = frame_width_next;
      res.height = frame_height_next;
      res.comps  = frame_components_next[1:0];
    end else begin
      res.width  = 16'd0;
      res.height = 16'd0;
      res.comps  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && is_last)) begin
      phase            <= PH_SOI0;
      bytes_seen       <= 3'd0;
      marker_code      <= 8'd0;
      segment_size     <= 16'd0;
      segment_progress <= 16'd0;
      sample_precision <= 8'd0;
      frame_height     <= 16'd0;
      frame_width      <= 16'd0;
      frame_components <= 8'd0;
      verdict_given    <= 1'b0;
    end else if (take) begin
      bytes_seen <= bytes_seen_next;
      if (!verdict_given) begin
        phase            <= phase_next;
        marker_code      <= marker_code_next;
        segment_size     <= segment_size_next;
        segment_progress <= segment_progress_next;
        sample_precision <= sample_precision_next;
        frame_height     <= frame_height_next;
        frame_width      <= frame_width_next;
        frame_components <= frame_components_next;
        verdict_given    <= hit;
      end
    end
  end

endmodule

// ===== hdl/jpeg_frame_header_scanner.sv =====
`timescale 1ns / 1ps

// Scans a JPEG file presented one byte per input transaction (is_last marks the
// final byte) and returns exactly one result transaction per file: status ok with
// the baseline frame width, height and component count, unsupported for other
// frame types, invalid for malformed data, or truncated when the file ends early
// (a file of fewer than four bytes is invalid). The parser never stalls, so one
// input transaction is accepted each clock while the output register is empty or
// being drained. The result is held in that output register; while a result
// waits there unaccepted, in_ready follows out_ready, so the byte source stalls
// until the result is taken. The result appears in the cycle after the byte that
// decides it; bytes after a decision are consumed silently up to the last byte,
// after which the parser is ready for the next file. max_dimension (reset 4096)
// is written through cfg_we/cfg_wdata and should only change between files.
module jpeg_frame_header_scanner import jfhs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] image_width,
  output logic [15:0] image_height,
  output logic [1:0]  component_count
);

  logic [15:0] max_dimension;
  logic        take;
  result_t     res;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_dimension <= MAX_DIM_RESET;
    end else if (cfg_we) begin
      max_dimension <= cfg_wdata;
    end
  end

  // A byte may enter whenever the output register is empty or is being drained.
  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  jfhs_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .data_byte     (data_byte),
    .is_last       (is_last),
    .max_dimension (max_dimension),
    .res           (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      status          <= res.status;
      image_width     <= res.width;
      image_height    <= res.height;
      component_count <= res.comps;
    end
  end

  // A good frame always reports nonzero dimensions and one or three components.
  a_ok_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |->
      image_width != 16'd0 && image_height != 16'd0 &&
      (component_count == 2'd1 || component_count == 2'd3))
    else $error("ok result with bad frame fields");

  // Any other outcome carries zero dimensions.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |->
      image_width == 16'd0 && image_height == 16'd0 && component_count == 2'd0)
    else $error("error result with nonzero fields");

  // A new result only follows an accepted byte.
  a_res_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without input transaction");

endmodule
